/* hdl/pds_pkg.sv */
// Shared types, codes and constants of the periodic deadline supervisor.
package pds_pkg;

    localparam int NUM_PROCS_DEF = 32;
    localparam int TICK_BITS_DEF = 32;

    typedef enum logic [2:0] {
        FN_SET_TIMING = 3'd0,
        FN_REARM      = 3'd1,
        FN_WAIT       = 3'd2,
        FN_REL_SCAN   = 3'd3,
        FN_DL_SCAN    = 3'd4,
        FN_TAKE_MISS  = 3'd5,
        FN_REARM_ALL  = 3'd6,
        FN_BAD        = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_INVALID_ARG   = 3'd1,
        ST_INVALID_STATE = 3'd2,
        ST_PENDING       = 3'd3,
        ST_BLOCK_FAILED  = 3'd4,
        ST_NO_MISS       = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  proc_id;
        logic [31:0] now;
        logic [31:0] new_period;
        logic [31:0] new_capacity;
        logic        is_running;
        logic        block_ok;
        logic [31:0] blocked_mask;
        logic [31:0] supervised_mask;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  event_count;
        logic [31:0] released_mask;
        logic [4:0]  miss_id;
        logic        miss_taken;
    } rsp_t;

endpackage

/* hdl/pds_stream_if.sv */
// Valid/ready channel carrying one payload.
interface pds_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/pds_cmp_unit.sv */
// Shared tick adder and unsigned comparator used by the sequencer's timing operations.
module pds_cmp_unit #(
    parameter int TICK_BITS = 32
) (
    input  logic [TICK_BITS-1:0] a,
    input  logic [TICK_BITS-1:0] b,
    input  logic [TICK_BITS-1:0] c,
    output logic [TICK_BITS-1:0] sum,
    output logic                 c_ge_b
);
    // Wrap the sum, compare c against b
    assign sum    = a + b;
    assign c_ge_b = (c >= b);
endmodule

/* hdl/periodic_deadline_supervisor.sv */
// Top level: timing table with a sequencer over one shared add/compare unit.
// Sequence: read, compute and advance per entry (states S_RD, S_A, S_NEXT), then S_OUT; periodic
// wait and release scan add a second compute state S_B; deadline scan, release scan and rearm all
// repeat the per-entry states over all NUM_PROCS entries before the response.
// Throughput: one transaction at a time; input is not ready until the result is taken.
// Reset: asynchronous; control state and valid bits clear, tables read as reset values.
module periodic_deadline_supervisor
    import pds_pkg::*;
#(
    parameter int NUM_PROCS = NUM_PROCS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    pds_stream_if.sink   req,
    pds_stream_if.source rsp
);
    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam logic [TICK_BITS-1:0] NONE = '1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_A    = 6'b000100,
        S_B    = 6'b001000,
        S_NEXT = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    req_t   rq_reg;
    rsp_t   rs_reg;
    logic [PW-1:0] idx_reg;
    logic [4:0]    mid;

    // Tables; valid bits give reset values
    logic [TICK_BITS-1:0] per_mem [NUM_PROCS];
    logic [TICK_BITS-1:0] cap_mem [NUM_PROCS];
    logic [TICK_BITS-1:0] rel_mem [NUM_PROCS];
    logic [TICK_BITS-1:0] dl_mem  [NUM_PROCS];
    logic [TICK_BITS-1:0] wk_mem  [NUM_PROCS];
    logic [31:0]          mc_mem  [NUM_PROCS];
    logic [NUM_PROCS-1:0] pv_reg, rv_reg, dv_reg, wv_reg, mv_reg, wait_reg;
    logic [31:0]          pend_reg;

    // Working registers of the current entry
    logic [TICK_BITS-1:0] per_r, cap_r, rel_r, dl_r, wk_r, nxt_r, now_t;
    logic [31:0] mc_r;
    logic        wt_r;

    // Shared unit operands
    logic [TICK_BITS-1:0] ua, ub, uc, usum;
    logic                 uge;

    pds_cmp_unit #(.TICK_BITS(TICK_BITS)) u_cmp (
        .a(ua), .b(ub), .c(uc), .sum(usum), .c_ge_b(uge)
    );

    logic [TICK_BITS-1:0] np_t, nc_t;
    logic pid_ok, scan, p_ok;
    logic [PW-1:0] pid;

    assign now_t  = TICK_BITS'(rq_reg.now);
    assign np_t   = TICK_BITS'(rq_reg.new_period);
    assign nc_t   = TICK_BITS'(rq_reg.new_capacity);
    assign pid    = rq_reg.proc_id[PW-1:0];
    assign pid_ok = 32'(rq_reg.proc_id) < 32'(NUM_PROCS);
    assign scan   = rq_reg.func == FN_REL_SCAN || rq_reg.func == FN_DL_SCAN
                 || rq_reg.func == FN_REARM_ALL;

    // Lowest pending miss
    always_comb
    begin
        mid = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                mid = 5'(i);
            end
        end
    end

    // Shared unit operand selection per state
    always_comb
    begin
        ua = rel_r;
        ub = cap_r;
        uc = now_t;
        case (state_reg)
            S_A:
            begin
                case (rq_reg.func)
                    FN_SET_TIMING: begin ua = now_t; ub = nc_t; uc = np_t; end
                    FN_REARM:      begin ua = now_t; ub = cap_r; end
                    FN_REARM_ALL:  begin ua = '0; ub = cap_r; end
                    FN_WAIT:       begin ua = rel_r; ub = per_r; end
                    FN_REL_SCAN:   begin ua = wk_r; ub = wk_r; end
                    default:       begin ua = dl_r; ub = dl_r; end
                endcase
            end
            S_B:
            begin
                case (rq_reg.func)
                    FN_WAIT:     begin ua = nxt_r; ub = nxt_r; end
                    FN_REL_SCAN: begin ua = wk_r; ub = cap_r; end
                    default:     begin ua = rel_r; ub = cap_r; end
                endcase
            end
            default: ;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = rs_reg;

    // Next-state sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req.valid) state_next = S_RD;
            S_RD:   state_next = S_A;
            S_A:    state_next = (rq_reg.func == FN_WAIT || rq_reg.func == FN_REL_SCAN)
                                 ? S_B : S_NEXT;
            S_B:    state_next = S_NEXT;
            S_NEXT: state_next = (scan && 32'(idx_reg) != 32'(NUM_PROCS - 1)) ? S_RD : S_OUT;
            S_OUT:  if (rsp.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign p_ok = scan || pid_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pv_reg <= '0; rv_reg <= '0; dv_reg <= '0; wv_reg <= '0; mv_reg <= '0;
            wait_reg <= '0; pend_reg <= '0; idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        rq_reg <= req.data;
                        idx_reg <= '0;
                        rs_reg <= '0;
                    end
                end
                S_RD:
                begin
                    // Fetch the addressed or scanned entry
                    if (scan)
                    begin
                        per_r <= pv_reg[idx_reg] ? per_mem[idx_reg] : '0;
                        cap_r <= pv_reg[idx_reg] ? cap_mem[idx_reg] : '0;
                        rel_r <= rv_reg[idx_reg] ? rel_mem[idx_reg] : '0;
                        dl_r  <= dv_reg[idx_reg] ? dl_mem[idx_reg] : NONE;
                        wk_r  <= wv_reg[idx_reg] ? wk_mem[idx_reg] : NONE;
                        mc_r  <= mv_reg[idx_reg] ? mc_mem[idx_reg] : '0;
                        wt_r  <= wait_reg[idx_reg];
                    end
                    else if (pid_ok)
                    begin
                        per_r <= pv_reg[pid] ? per_mem[pid] : '0;
                        cap_r <= pv_reg[pid] ? cap_mem[pid] : '0;
                        rel_r <= rv_reg[pid] ? rel_mem[pid] : '0;
                        dl_r  <= dv_reg[pid] ? dl_mem[pid] : NONE;
                        wk_r  <= wv_reg[pid] ? wk_mem[pid] : NONE;
                        mc_r  <= mv_reg[pid] ? mc_mem[pid] : '0;
                        wt_r  <= wait_reg[pid];
                    end
                    if (rq_reg.func == FN_TAKE_MISS)
                    begin
                        if (pend_reg == '0)
                            rs_reg.status <= ST_NO_MISS;
                        else
                        begin
                            rs_reg.miss_id <= mid;
                            rs_reg.miss_taken <= 1'b1;
                            pend_reg[mid] <= 1'b0;
                        end
                    end
                    else if (rq_reg.func == FN_BAD || !p_ok)
                        rs_reg.status <= ST_INVALID_ARG;
                end
                S_A:
                begin
                    case (rq_reg.func)
                        FN_SET_TIMING:
                        begin
                            if (pid_ok && !(np_t != '0 && !uge && nc_t != np_t))
                            begin
                                per_mem[pid] <= np_t; cap_mem[pid] <= nc_t; pv_reg[pid] <= 1'b1;
                                rel_mem[pid] <= now_t; rv_reg[pid] <= 1'b1;
                                dl_mem[pid] <= (nc_t != '0) ? usum : NONE; dv_reg[pid] <= 1'b1;
                                wait_reg[pid] <= 1'b0;
                            end
                            else
                                rs_reg.status <= ST_INVALID_ARG;
                        end
                        FN_REARM:
                        begin
                            if (pid_ok)
                            begin
                                rel_mem[pid] <= now_t; rv_reg[pid] <= 1'b1;
                                dl_mem[pid] <= (cap_r != '0) ? usum : NONE; dv_reg[pid] <= 1'b1;
                                wait_reg[pid] <= 1'b0;
                            end
                        end
                        FN_REARM_ALL:
                        begin
                            rel_mem[idx_reg] <= '0; rv_reg[idx_reg] <= 1'b1;
                            dl_mem[idx_reg] <= (cap_r != '0) ? usum : NONE;
                            dv_reg[idx_reg] <= 1'b1;
                            wait_reg[idx_reg] <= 1'b0;
                        end
                        FN_WAIT:
                        begin
                            nxt_r <= usum;
                            if (pid_ok && (!rq_reg.is_running || per_r == '0))
                                rs_reg.status <= ST_INVALID_STATE;
                        end
                        FN_REL_SCAN:
                        begin
                            // Release when blocked, waiting and wake tick reached
                            wt_r <= rq_reg.blocked_mask[idx_reg] && wt_r && uge;
                        end
                        FN_DL_SCAN:
                        begin
                            if (rq_reg.supervised_mask[idx_reg] && dl_r != NONE && uge)
                            begin
                                dl_mem[idx_reg] <= NONE; dv_reg[idx_reg] <= 1'b1;
                                mc_mem[idx_reg] <= mc_r + 32'd1; mv_reg[idx_reg] <= 1'b1;
                                pend_reg[idx_reg] <= 1'b1;
                                rs_reg.event_count <= rs_reg.event_count + 6'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_B:
                begin
                    if (rq_reg.func == FN_WAIT)
                    begin
                        if (pid_ok && rq_reg.is_running && per_r != '0)
                        begin
                            dv_reg[pid] <= 1'b1;
                            if (uge)
                            begin
                                rel_mem[pid] <= nxt_r; rv_reg[pid] <= 1'b1;
                                rel_r <= nxt_r;
                            end
                            else if (rq_reg.block_ok)
                            begin
                                dl_mem[pid] <= NONE;
                                wait_reg[pid] <= 1'b1;
                                wk_mem[pid] <= nxt_r; wv_reg[pid] <= 1'b1;
                                rs_reg.status <= ST_PENDING;
                            end
                            else
                                rs_reg.status <= ST_BLOCK_FAILED;
                            // Mark deadline rearm for next state via wt_r flag
                            wt_r <= uge || !rq_reg.block_ok;
                        end
                        else
                            wt_r <= 1'b0;
                    end
                    else if (wt_r)
                    begin
                        rel_mem[idx_reg] <= wk_r; rv_reg[idx_reg] <= 1'b1;
                        wk_mem[idx_reg] <= NONE; wv_reg[idx_reg] <= 1'b1;
                        wait_reg[idx_reg] <= 1'b0;
                        dl_mem[idx_reg] <= (cap_r != '0) ? usum : NONE;
                        dv_reg[idx_reg] <= 1'b1;
                        rs_reg.released_mask[5'(idx_reg)] <= 1'b1;
                        rs_reg.event_count <= rs_reg.event_count + 6'd1;
                    end
                end
                S_NEXT:
                begin
                    // Rearm deadline for periodic wait from the current release
                    if (rq_reg.func == FN_WAIT && wt_r)
                        dl_mem[pid] <= (cap_r != '0) ? usum : NONE;
                    if (scan)
                        idx_reg <= idx_reg + PW'(1);
                end
                default: ;
            endcase
        end
    end
endmodule

/* tb/periodic_deadline_supervisor_tb.sv */
// Testbench for the periodic deadline supervisor: random and directed requests, scoreboard.
module periodic_deadline_supervisor_tb;
    import pds_pkg::*;

    localparam int NPROC = 32;
    localparam logic [31:0] TICK_NONE = 32'hFFFF_FFFF;

    // Timing table mirror; predicts one response per accepted request
    class timing_scoreboard;
        logic [31:0] period_tbl[NPROC];
        logic [31:0] capacity_tbl[NPROC];
        logic [31:0] release_tbl[NPROC];
        logic [31:0] deadline_tbl[NPROC];
        logic [31:0] wake_tbl[NPROC];
        bit          waiting[NPROC];
        logic [31:0] miss_cnt[NPROC];
        logic [31:0] pending;
        rsp_t        expected_rsps[$];
        int          errors;

        function new();
            for (int p = 0; p < NPROC; p++)
            begin
                period_tbl[p] = '0;
                capacity_tbl[p] = '0;
                release_tbl[p] = '0;
                deadline_tbl[p] = TICK_NONE;
                wake_tbl[p] = TICK_NONE;
                waiting[p] = 0;
                miss_cnt[p] = '0;
            end
            pending = '0;
            errors = 0;
        endfunction

        function void refresh_deadline(int p);
            if (capacity_tbl[p] != 0)
                deadline_tbl[p] = release_tbl[p] + capacity_tbl[p];
            else
                deadline_tbl[p] = TICK_NONE;
        endfunction

        function void rearm(int p, logic [31:0] at);
            waiting[p] = 0;
            release_tbl[p] = at;
            refresh_deadline(p);
        endfunction

        function void note_request(req_t r);
            rsp_t        e;
            logic [31:0] next_rel;
            int          p;
            e = '0;
            e.status = ST_OK;
            p = int'(r.proc_id);
            case (func_t'(r.func))
                FN_SET_TIMING:
                    if (r.new_period != 0 && r.new_capacity > r.new_period)
                        e.status = ST_INVALID_ARG;
                    else
                    begin
                        period_tbl[p] = r.new_period;
                        capacity_tbl[p] = r.new_capacity;
                        rearm(p, r.now);
                    end
                FN_REARM: rearm(p, r.now);
                FN_WAIT:
                    if (!r.is_running || period_tbl[p] == 0)
                        e.status = ST_INVALID_STATE;
                    else
                    begin
                        next_rel = release_tbl[p] + period_tbl[p];
                        deadline_tbl[p] = TICK_NONE;
                        if (r.now >= next_rel)
                        begin
                            release_tbl[p] = next_rel;
                            refresh_deadline(p);
                        end
                        else if (r.block_ok)
                        begin
                            waiting[p] = 1;
                            wake_tbl[p] = next_rel;
                            e.status = ST_PENDING;
                        end
                        else
                        begin
                            refresh_deadline(p);
                            e.status = ST_BLOCK_FAILED;
                        end
                    end
                FN_REL_SCAN:
                    for (int i = 0; i < NPROC; i++)
                        if (r.blocked_mask[i] && waiting[i] && r.now >= wake_tbl[i])
                        begin
                            release_tbl[i] = wake_tbl[i];
                            wake_tbl[i] = TICK_NONE;
                            waiting[i] = 0;
                            refresh_deadline(i);
                            e.released_mask[i] = 1'b1;
                            e.event_count++;
                        end
                FN_DL_SCAN:
                    for (int i = 0; i < NPROC; i++)
                        if (r.supervised_mask[i] && deadline_tbl[i] != TICK_NONE &&
                            r.now >= deadline_tbl[i])
                        begin
                            deadline_tbl[i] = TICK_NONE;
                            miss_cnt[i]++;
                            pending[i] = 1'b1;
                            e.event_count++;
                        end
                FN_TAKE_MISS:
                    if (pending == 0)
                        e.status = ST_NO_MISS;
                    else
                        for (int i = NPROC - 1; i >= 0; i--)
                            if (pending[i])
                                e.miss_id = 5'(i);
                FN_REARM_ALL:
                    for (int i = 0; i < NPROC; i++)
                        rearm(i, '0);
                default: e.status = ST_INVALID_ARG;
            endcase
            // Pop the chosen miss after the search
            if (func_t'(r.func) == FN_TAKE_MISS && pending != 0)
            begin
                pending[e.miss_id] = 1'b0;
                e.miss_taken = 1'b1;
            end
            expected_rsps.push_back(e);
        endfunction

        function void check_response(rsp_t a);
            rsp_t e;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
                return;
            end
            e = expected_rsps.pop_front();
            if (a.status !== e.status)
                $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            if (a.event_count !== e.event_count)
                $display("%0t: event_count expected %0d actual %0d", $time,
                         e.event_count, a.event_count);
            if (a.released_mask !== e.released_mask)
                $display("%0t: released_mask expected %h actual %h", $time,
                         e.released_mask, a.released_mask);
            if (a.miss_id !== e.miss_id)
                $display("%0t: miss_id expected %0d actual %0d", $time, e.miss_id, a.miss_id);
            if (a.miss_taken !== e.miss_taken)
                $display("%0t: miss_taken expected %0d actual %0d", $time,
                         e.miss_taken, a.miss_taken);
            if (a !== e)
                errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    pds_stream_if #(.payload_t(req_t)) req_ch();
    pds_stream_if #(.payload_t(rsp_t)) rsp_ch();

    periodic_deadline_supervisor DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch.sink),
        .rsp(rsp_ch.source)
    );

    timing_scoreboard sb = new();
    int send_idle_pct = 28;
    int recv_idle_pct = 75;
    logic [31:0] tick_base = 32'd1000;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    initial
    begin
        req_ch.valid = 0;
        req_ch.data = '0;
        rsp_ch.ready = 0;
    end

    // Check responses and stall the response side at random
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.data);
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one request, with a random gap first, and hold it until accepted
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(r);
    endtask

    function automatic req_t make_req(func_t f, int pid, logic [31:0] now_t);
        req_t r;
        r = '0;
        r.func = f;
        r.proc_id = 5'(pid);
        r.now = now_t;
        r.is_running = 1'b1;
        r.block_ok = 1'b1;
        r.blocked_mask = '1;
        r.supervised_mask = '1;
        return r;
    endfunction

    // Random request, mostly well-formed periodic activity near the running tick
    function automatic req_t random_req();
        req_t r;
        int   k;
        r.func = 3'($urandom_range(7));
        r.proc_id = 5'($urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(5));
        k = $urandom_range(9);
        tick_base = tick_base + $urandom_range(12);
        r.now = (k == 0) ? $urandom : (k == 1) ? TICK_NONE - $urandom_range(20) : tick_base;
        r.new_period = (k == 2) ? $urandom : $urandom_range(30);
        r.new_capacity = (k == 3) ? $urandom : $urandom_range(r.new_period + 2);
        r.is_running = $urandom_range(7) != 0;
        r.block_ok = $urandom_range(3) != 0;
        r.blocked_mask = $urandom_range(3) == 0 ? $urandom : '1;
        r.supervised_mask = $urandom_range(3) == 0 ? $urandom : '1;
        if ($urandom_range(5) == 0)
            r.func = FN_TAKE_MISS;
        return r;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_request(random_req());
    endtask

    initial
    begin
        req_t r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every operation, special cases
        send_request(make_req(FN_TAKE_MISS, 0, 0));
        r = make_req(FN_SET_TIMING, 31, TICK_NONE);
        r.new_period = 10; r.new_capacity = 11;
        send_request(r);
        r.new_period = 0; r.new_capacity = '1;
        send_request(r);
        r = make_req(FN_SET_TIMING, 0, 32'hFFFF_FFF0);
        r.new_period = 32; r.new_capacity = 15;
        send_request(r);
        send_request(make_req(FN_WAIT, 0, 32'h0000_0005));
        send_request(make_req(FN_REL_SCAN, 0, TICK_NONE));
        r = make_req(FN_WAIT, 0, 5); r.block_ok = 0;
        send_request(r);
        r = make_req(FN_WAIT, 0, 5); r.is_running = 0;
        send_request(r);
        send_request(make_req(FN_WAIT, 5, 5));
        send_request(make_req(FN_DL_SCAN, 0, TICK_NONE - 1));
        send_request(make_req(FN_TAKE_MISS, 0, 0));
        send_request(make_req(FN_TAKE_MISS, 0, 0));
        r = make_req(FN_SET_TIMING, 7, 0);
        r.new_period = '1; r.new_capacity = '1;
        send_request(r);
        r = make_req(FN_REARM, 7, 1);
        send_request(r);
        r = make_req(FN_DL_SCAN, 0, TICK_NONE); r.supervised_mask = '0;
        send_request(r);
        send_request(make_req(FN_BAD, 31, 0));
        send_request(make_req(FN_REARM_ALL, 0, TICK_NONE));
        send_request(make_req(FN_DL_SCAN, 0, TICK_NONE));

        run_random(350);
        send_idle_pct = 75; recv_idle_pct = 28;
        run_random(350);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(350);
        req_ch.valid <= 1'b0;

        while (sb.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

/* filelist.f */
hdl/pds_pkg.sv
hdl/pds_stream_if.sv
hdl/pds_cmp_unit.sv
hdl/periodic_deadline_supervisor.sv
tb/periodic_deadline_supervisor_tb.sv
